// ===== sv/afhd_pkg.sv =====
// ----------------------------------------------------------------------------
// afhd_pkg
// Shared types, codes and lookup tables for the audio frame header decoder.
// ----------------------------------------------------------------------------
package afhd_pkg;

  localparam int MaxFrameBytesDef = 8192;

  // Header format selector.
  localparam logic OP_MPEG = 1'b0;
  localparam logic OP_ADTS = 1'b1;

  // MPEG version field codes.
  localparam logic [1:0] MPEG_VER_25   = 2'b00;
  localparam logic [1:0] MPEG_VER_RSVD = 2'b01;
  localparam logic [1:0] MPEG_VER_2    = 2'b10;
  localparam logic [1:0] MPEG_VER_1    = 2'b11;
  localparam logic [1:0] MPEG_LAYER_3  = 2'b01;
  localparam logic [1:0] MPEG_MODE_MONO = 2'b11;

  // Division by 49 as a multiply by a rounded-up reciprocal and a shift.
  // The error stays below 1/49 over the 16-bit numerator range.
  localparam int          DivShift = 22;
  localparam int          NumW     = 16;
  localparam int          RecipW   = 17;
  localparam int          ProdW    = NumW + RecipW;
  localparam int          QuotW    = 11;
  localparam logic [RecipW-1:0] Recip49 = 17'd85599;

  // How the frame length is formed in the back stages.
  typedef enum logic [1:0] {
    SEL_ADTS = 2'd0,  // length carried in the header
    SEL_44K  = 2'd1,  // 160 * x / 49
    SEL_48K  = 2'd2,  // 3 * x
    SEL_32K  = 2'd3   // 9 * x / 2
  } sel_e;

  typedef struct packed {
    logic            ok;
    sel_e            sel;
    logic            pad;
    logic [NumW-1:0] val;
    logic [16:0]     rate;
    logic [3:0]      ch;
  } pipe_t;

  function automatic logic [8:0] kbps_v1(input logic [3:0] idx);
    logic [8:0] k;
    unique case (idx)
      4'd1:    k = 9'd32;
      4'd2:    k = 9'd40;
      4'd3:    k = 9'd48;
      4'd4:    k = 9'd56;
      4'd5:    k = 9'd64;
      4'd6:    k = 9'd80;
      4'd7:    k = 9'd96;
      4'd8:    k = 9'd112;
      4'd9:    k = 9'd128;
      4'd10:   k = 9'd160;
      4'd11:   k = 9'd192;
      4'd12:   k = 9'd224;
      4'd13:   k = 9'd256;
      4'd14:   k = 9'd320;
      default: k = 9'd0;
    endcase
    return k;
  endfunction

  function automatic logic [8:0] kbps_v2(input logic [3:0] idx);
    logic [8:0] k;
    unique case (idx)
      4'd1:    k = 9'd8;
      4'd2:    k = 9'd16;
      4'd3:    k = 9'd24;
      4'd4:    k = 9'd32;
      4'd5:    k = 9'd40;
      4'd6:    k = 9'd48;
      4'd7:    k = 9'd56;
      4'd8:    k = 9'd64;
      4'd9:    k = 9'd80;
      4'd10:   k = 9'd96;
      4'd11:   k = 9'd112;
      4'd12:   k = 9'd128;
      4'd13:   k = 9'd144;
      4'd14:   k = 9'd160;
      default: k = 9'd0;
    endcase
    return k;
  endfunction

  function automatic logic [16:0] mpeg_base_rate(input logic [1:0] idx);
    logic [16:0] r;
    unique case (idx)
      2'd0:    r = 17'd44100;
      2'd1:    r = 17'd48000;
      2'd2:    r = 17'd32000;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] adts_rate(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/audio_frame_header_decode_top.sv =====
// ----------------------------------------------------------------------------
// audio_frame_header_decode_top
// Checks one MPEG Layer III or ADTS header candidate per beat and reports
// whether it is valid, with its frame length, sample rate and channel count.
// ----------------------------------------------------------------------------
// Usage: each input beat carries the six bytes at a candidate position, the
// count of bytes available there (tdata) and the format selector (tuser,
// 0 for MPEG Layer III, 1 for ADTS). Each input beat gives exactly one
// output beat: header_valid in tuser, frame length, rate and channel count
// in tdata, all zero for a rejected header.
// The block is a four-stage pipeline: field decode and table lookup, the
// numerator of the length, a 16 x 17 multiply that divides by 49 through
// a reciprocal, and the final select, padding add and range check. A beat
// passes the stages in order; one beat is taken every cycle unless stalled.
// The multiply stage sets the clock; there is no other loop.
// Each stage has its own valid bit and ready, so a stalled output holds its
// beat while earlier stages keep filling empty slots; nothing is lost or
// repeated. Reset clears all valid bits; the pipeline is empty afterward.
module audio_frame_header_decode_top #(
  parameter int MAX_FRAME_BYTES = afhd_pkg::MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // header_byte0[7:0], header_byte1 .. header_byte5, bytes_available[50:48]
  input  logic [55:0] s_axis_tdata,
  // op[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_length[13:0], sample_rate[30:14], channel_count[34:31]
  output logic [39:0] m_axis_tdata,
  // header_valid[0]
  output logic [0:0]  m_axis_tuser
);
  import afhd_pkg::*;

  localparam logic [13:0] MaxLen = 14'(MAX_FRAME_BYTES);

  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [2:0] avail;
  logic       op;

  assign b0    = s_axis_tdata[7:0];
  assign b1    = s_axis_tdata[15:8];
  assign b2    = s_axis_tdata[23:16];
  assign b3    = s_axis_tdata[31:24];
  assign b4    = s_axis_tdata[39:32];
  assign b5    = s_axis_tdata[47:40];
  assign avail = s_axis_tdata[50:48];
  assign op    = s_axis_tuser[0];

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = ~v4_q | m_axis_tready;
  assign rdy3 = ~v3_q | rdy4;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;
  assign s_axis_tready = rdy1;

  // ---------------- Stage 1: decode ----------------
  pipe_t st1_d, st1_q;

  logic [1:0]  ver, lay, msri;
  logic [3:0]  bri, asri;
  logic [8:0]  kbps;
  logic [16:0] mbase;
  logic        mpeg_ok, adts_ok;
  logic [2:0]  cfg;
  logic [12:0] alen;

  always_comb begin
    ver   = b1[4:3];
    lay   = b1[2:1];
    bri   = b2[7:4];
    msri  = b2[3:2];
    kbps  = (ver == MPEG_VER_1) ? kbps_v1(bri) : kbps_v2(bri);
    mbase = mpeg_base_rate(msri);
    mpeg_ok = (avail >= 3'd4) && (b0 == 8'hFF) && (b1[7:5] == 3'b111) &&
              (ver != MPEG_VER_RSVD) && (lay == MPEG_LAYER_3) &&
              (kbps != 9'd0) && (msri != 2'd3);

    asri = b2[5:2];
    cfg  = {b2[0], b3[7:6]};
    alen = {b3[1:0], b4, b5[7:5]};
    adts_ok = (avail == 3'd7) && (b0 == 8'hFF) && ((b1 & 8'hF6) == 8'hF0) &&
              (asri < 4'd13);

    st1_d = '0;
    if (op == OP_ADTS) begin
      st1_d.ok   = adts_ok;
      st1_d.sel  = SEL_ADTS;
      st1_d.pad  = 1'b0;
      st1_d.val  = NumW'(alen);
      st1_d.rate = adts_rate(asri);
      st1_d.ch   = (cfg == 3'd0) ? 4'd1 : ((cfg == 3'd7) ? 4'd8 : {1'b0, cfg});
    end else begin
      st1_d.ok  = mpeg_ok;
      st1_d.pad = b2[1];
      // MPEG 2.5 halves the rate again against MPEG 2, so its bitrate is
      // doubled to share the MPEG 1 divisors.
      st1_d.val = (ver == MPEG_VER_25) ? NumW'({kbps, 1'b0}) : NumW'(kbps);
      case (msri)
        2'd0:    st1_d.sel = SEL_44K;
        2'd1:    st1_d.sel = SEL_48K;
        default: st1_d.sel = SEL_32K;
      endcase
      case (ver)
        MPEG_VER_1: st1_d.rate = mbase;
        MPEG_VER_2: st1_d.rate = {1'b0, mbase[16:1]};
        default:    st1_d.rate = {2'b00, mbase[16:2]};
      endcase
      st1_d.ch = (b3[7:6] == MPEG_MODE_MONO) ? 4'd1 : 4'd2;
    end
  end

  // ---------------- Stage 2: numerator ----------------
  pipe_t st2_d, st2_q;

  always_comb begin
    st2_d = st1_q;
    case (st1_q.sel)
      SEL_44K: st2_d.val = (st1_q.val << 7) + (st1_q.val << 5);
      SEL_48K: st2_d.val = (st1_q.val << 1) + st1_q.val;
      SEL_32K: st2_d.val = (st1_q.val << 3) + st1_q.val;
      default: st2_d.val = st1_q.val;
    endcase
  end

  // ---------------- Stage 3: reciprocal multiply ----------------
  pipe_t            st3_q;
  logic [ProdW-1:0] prod_d, prod_q;

  assign prod_d = ProdW'(st2_q.val) * ProdW'(Recip49);

  // ---------------- Stage 4: length, range check, output ----------------
  logic [13:0] quot, flen, min_len;
  logic        ok4;
  logic [39:0] out_data_d, out_data_q;
  logic        out_ok_d, out_ok_q;

  always_comb begin
    case (st3_q.sel)
      SEL_44K: quot = 14'(prod_q[DivShift+QuotW-1:DivShift]);
      SEL_32K: quot = st3_q.val[14:1];
      default: quot = st3_q.val[13:0];
    endcase
    flen    = quot + 14'(st3_q.pad);
    min_len = (st3_q.sel == SEL_ADTS) ? 14'd7 : 14'd4;
    ok4     = st3_q.ok && (flen >= min_len) && (flen <= MaxLen);
    out_ok_d   = ok4;
    out_data_d = ok4 ? {5'd0, st3_q.ch, st3_q.rate, flen} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) st1_q <= st1_d;
    if (rdy2) st2_q <= st2_d;
    if (rdy3) begin
      st3_q  <= st2_q;
      prod_q <= prod_d;
    end
    if (rdy4) begin
      out_data_q <= out_data_d;
      out_ok_q   <= out_ok_d;
    end
  end

  assign m_axis_tvalid   = v4_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ok_q;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("rejected header with nonzero result fields");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[13:0] >= 14'd4 && m_axis_tdata[13:0] <= MaxLen)
    else $error("accepted header with frame length out of range");

  a_rate_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] == (m_axis_tdata[30:14] != 17'd0))
    else $error("sample rate disagrees with header valid flag");

  a_ch_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[34:31] != 4'd0 && m_axis_tdata[34:31] <= 4'd8)
    else $error("accepted header with bad channel count");
`endif

endmodule
